// ===== src/next_representable_ext80_assert.svh =====
// Assertion macros for the next-representable block
`ifndef NEXT_REPRESENTABLE_EXT80_ASSERT_SVH
`define NEXT_REPRESENTABLE_EXT80_ASSERT_SVH

`define NRX_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define NRX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/nrx_pkg.sv =====
package nrx_pkg;
  localparam logic [14:0] ExpMax   = 15'h7fff;
  localparam logic [15:0] DnanSe   = 16'hffff;
  localparam logic [63:0] DnanSig  = 64'hC000000000000000;
  localparam logic [62:0] Low63    = {63{1'b1}};
  localparam logic [63:0] QuietBit = 64'h4000000000000000;
  localparam logic [63:0] IntBit   = 64'h8000000000000000;

  typedef struct packed {
    logic [15:0] sign_exp;
    logic [63:0] significand;
    logic        underflow;
    logic        overflow;
  } nrx_res_t;
endpackage

// ===== src/next_representable_ext80.sv =====
// next_representable_ext80: neighbour of x toward y for x87 80-bit extended values.
// Input channel: in_valid / in_stall with x and y as sign-exponent word and
// 64-bit significand. A transfer happens when in_valid is high and in_stall low.
// Result channel: out_valid / out_stall with result word, significand and the
// underflow and overflow flags; out_stall from the receiver holds the result.
// Timing: out_valid rises in the cycle after the input transfer, through a single
// register stage after the stepping logic (compare, 64-bit increment or
// decrement, exponent carry).
// Throughput: one item per cycle; in_stall follows out_stall only when the
// result register is full and stalled.
// Reset: rst_n low clears out_valid; no result is pending afterwards.
// Stall: a valid result holds its value in the result register while out_stall is high, and
// a new transfer is taken in the same cycle the old result leaves.
// The block keeps no state between items.
module next_representable_ext80 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_x_sign_exp,
  input  logic [63:0] in_x_significand,
  input  logic [15:0] in_y_sign_exp,
  input  logic [63:0] in_y_significand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result_sign_exp,
  output logic [63:0] out_result_significand,
  output logic        out_underflow_flag,
  output logic        out_overflow_flag
);
  import nrx_pkg::*;
  `include "next_representable_ext80_assert.svh"

  logic     valid_r;
  nrx_res_t res_r, res_nxt;
  logic     take;

  logic [14:0] xe, ye, ex, ey, e;
  logic        xinv, yinv, xnan, ynan, xz, yz, xn, yn;
  logic        mag_lt, mag_eq, val_eq, val_gt, shrink;
  logic [63:0] xs, ys, rs;

  assign in_stall = valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  always_comb begin
    xs   = in_x_significand;
    ys   = in_y_significand;
    xe   = in_x_sign_exp[14:0];
    ye   = in_y_sign_exp[14:0];
    xn   = in_x_sign_exp[15];
    yn   = in_y_sign_exp[15];
    xinv = (xe != '0) && !xs[63];
    yinv = (ye != '0) && !ys[63];
    xnan = (xe == ExpMax) && (xs[62:0] != '0);
    ynan = (ye == ExpMax) && (ys[62:0] != '0);
    xz   = (xs == '0);
    yz   = (ys == '0);
    ex   = (xe == '0 && xs[63]) ? 15'd1 : xe;
    ey   = (ye == '0 && ys[63]) ? 15'd1 : ye;
    mag_eq = (ex == ey) && (xs == ys);
    mag_lt = (ex < ey) || ((ex == ey) && (xs < ys));
    val_eq = (xz && yz) || (!xz && !yz && xn == yn && mag_eq);
    if (xz)          val_gt = yn;
    else if (yz)     val_gt = !xn;
    else if (xn != yn) val_gt = !xn;
    else             val_gt = xn ? mag_lt : !mag_lt;
    shrink = (!xn && val_gt) || (xn && !val_gt);
    e  = ex;
    rs = xs;
    if (shrink) begin
      rs = xs - 64'd1;
      if (rs[62:0] == Low63 && !rs[63]) begin
        e = ex - 15'd1;
        if (e != '0) rs = rs | IntBit;
      end
    end else begin
      rs = xs + 64'd1;
      if (rs[62:0] == '0) begin
        rs = IntBit;
        e  = ex + 15'd1;
      end
    end
    res_nxt = '0;
    if (xinv || yinv) begin
      res_nxt.sign_exp    = DnanSe;
      res_nxt.significand = DnanSig;
    end else if (xnan || ynan) begin
      if (xnan && (!ynan || xs >= ys)) begin
        res_nxt.sign_exp    = in_x_sign_exp;
        res_nxt.significand = xs | QuietBit;
      end else begin
        res_nxt.sign_exp    = in_y_sign_exp;
        res_nxt.significand = ys | QuietBit;
      end
    end else if (val_eq) begin
      res_nxt.sign_exp    = in_y_sign_exp;
      res_nxt.significand = ys;
    end else begin
      if (xz) begin
        res_nxt.sign_exp    = {yn, 15'd0};
        res_nxt.significand = 64'd1;
      end else begin
        res_nxt.sign_exp    = {xn, e};
        res_nxt.significand = rs;
      end
      res_nxt.underflow = (res_nxt.sign_exp[14:0] == '0);
      res_nxt.overflow  = (res_nxt.sign_exp[14:0] == ExpMax);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = valid_r;
  assign out_result_sign_exp    = res_r.sign_exp;
  assign out_result_significand = res_r.significand;
  assign out_underflow_flag     = res_r.underflow;
  assign out_overflow_flag      = res_r.overflow;

  `NRX_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")
  `NRX_ASSERT_CLK(a_take_fill, take |=> out_valid, "accepted item not presented")
  `NRX_ASSERT_CLK(a_hold, (out_valid && out_stall) |=> ($stable(res_r) && out_valid),
    "stalled result changed")
  `NRX_ASSERT_CLK(a_flags, out_valid |-> !(out_underflow_flag && out_overflow_flag),
    "both flags set")
endmodule

// ===== tb/next_representable_ext80_tb.sv =====
`timescale 1ns / 100ps

class nrx_scoreboard;
  logic [81:0] pending[$];
  int errors;

  function void note_input(logic [15:0] xse, logic [63:0] xs, logic [15:0] yse,
                           logic [63:0] ys);
    logic [15:0] rse;
    logic [63:0] rs;
    logic [14:0] xe, ye, e;
    logic xinv, yinv, xnan, ynan, xn, yn;
    int c, m;
    logic [14:0] ex, ey;
    xe = xse[14:0];
    ye = yse[14:0];
    xinv = (xe != 0) && !xs[63];
    yinv = (ye != 0) && !ys[63];
    xnan = (xe == nrx_pkg::ExpMax) && (xs[62:0] != 0);
    ynan = (ye == nrx_pkg::ExpMax) && (ys[62:0] != 0);
    if (xinv || yinv) begin
      pending.push_back({nrx_pkg::DnanSe, nrx_pkg::DnanSig, 2'b00});
      return;
    end
    if (xnan || ynan) begin
      if (xnan && (!ynan || xs >= ys))
        pending.push_back({xse, xs | nrx_pkg::QuietBit, 2'b00});
      else
        pending.push_back({yse, ys | nrx_pkg::QuietBit, 2'b00});
      return;
    end
    xn = xse[15];
    yn = yse[15];
    ex = (xe == 0 && xs[63]) ? 15'd1 : xe;
    ey = (ye == 0 && ys[63]) ? 15'd1 : ye;
    m = (ex != ey) ? ((ex < ey) ? -1 : 1) : ((xs != ys) ? ((xs < ys) ? -1 : 1) : 0);
    if (xs == 0 && ys == 0) c = 0;
    else if (xs == 0) c = yn ? 1 : -1;
    else if (ys == 0) c = xn ? -1 : 1;
    else if (xn != yn) c = xn ? -1 : 1;
    else c = xn ? -m : m;
    if (c == 0) begin
      pending.push_back({yse, ys, 2'b00});
      return;
    end
    if (xs == 0) begin
      rse = {yn, 15'd0};
      rs = 64'd1;
    end else begin
      e = ex;
      rs = xs;
      if ((!xn && c > 0) || (xn && c < 0)) begin
        rs = rs - 64'd1;
        if (rs == {1'b0, nrx_pkg::Low63}) begin
          e = e - 15'd1;
          if (e != 0) rs[63] = 1'b1;
        end
      end else begin
        rs = rs + 64'd1;
        if (rs[62:0] == 0) begin
          rs = nrx_pkg::IntBit;
          e = e + 15'd1;
        end
      end
      rse = {xn, e};
    end
    pending.push_back({rse, rs, rse[14:0] == 0, rse[14:0] == nrx_pkg::ExpMax});
  endfunction

  function void check_result(logic [15:0] se, logic [63:0] s, logic uf, logic of);
    logic [81:0] w;
    if (pending.size() == 0) begin
      $error("result with nothing expected");
      errors++;
      return;
    end
    w = pending.pop_front();
    if (se !== w[81:66]) begin
      $error("result_sign_exp exp %h got %h", w[81:66], se); errors++;
    end
    if (s !== w[65:2]) begin
      $error("result_significand exp %h got %h", w[65:2], s); errors++;
    end
    if (uf !== w[1]) begin
      $error("underflow_flag exp %b got %b", w[1], uf); errors++;
    end
    if (of !== w[0]) begin
      $error("overflow_flag exp %b got %b", w[0], of); errors++;
    end
  endfunction
endclass

module next_representable_ext80_tb;
  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  logic [15:0] in_x_sign_exp, in_y_sign_exp, out_result_sign_exp;
  logic [63:0] in_x_significand, in_y_significand, out_result_significand;
  logic out_underflow_flag, out_overflow_flag;
  int send_idle, recv_stall, quiet_cycles, n_in, n_out;
  nrx_scoreboard sb;

  next_representable_ext80 u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_input(in_x_sign_exp, in_x_significand, in_y_sign_exp, in_y_significand);
        n_in++;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_result_sign_exp, out_result_significand,
                        out_underflow_flag, out_overflow_flag);
        n_out++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 2000) begin
        $display("Regression FAIL");
        $finish;
      end
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  function automatic logic [63:0] rand_sig();
    logic [63:0] s;
    s = {$urandom, $urandom};
    case ($urandom_range(7))
      0: s = 64'd0;
      1: s = 64'd1;
      2: s = 64'hffffffffffffffff;
      3: s = 64'h8000000000000000;
      4: s = {1'b0, {63{1'b1}}};
      5: s = 64'h8000000000000001;
      default: s[63] = ($urandom_range(9) != 0);
    endcase
    return s;
  endfunction

  function automatic logic [15:0] rand_se();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(7))
      0: v[14:0] = 15'd0;
      1: v[14:0] = 15'h7fff;
      2: v[14:0] = 15'h7ffe;
      3: v[14:0] = 15'd1;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send(logic [15:0] xse, logic [63:0] xs, logic [15:0] yse,
                      logic [63:0] ys);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_sign_exp <= xse;
    in_x_significand <= xs;
    in_y_sign_exp <= yse;
    in_y_significand <= ys;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_items(int n);
    logic [15:0] xse, yse;
    logic [63:0] xs, ys;
    repeat (n) begin
      xse = rand_se();
      xs = rand_sig();
      if ($urandom_range(3) == 0) begin
        yse = xse;
        ys = xs;
        if ($urandom_range(1)) ys = $urandom_range(1) ? ys + 64'd1 : ys - 64'd1;
        if ($urandom_range(3) == 0) yse[15] = ~yse[15];
      end else begin
        yse = rand_se();
        ys = rand_sig();
      end
      send(xse, xs, yse, ys);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    in_x_sign_exp = 0;
    in_x_significand = 0;
    in_y_sign_exp = 0;
    in_y_significand = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(16'h3fff, 64'h8000000000000000, 16'h4000, 64'h8000000000000000);
    send(16'h3fff, 64'h8000000000000000, 16'h3ffe, 64'h8000000000000000);
    send(16'hbfff, 64'h8000000000000000, 16'h0000, 64'h0);
    send(16'h0000, 64'h0, 16'h8000, 64'h5);
    send(16'h8000, 64'h0, 16'h0000, 64'h0);
    send(16'h0000, 64'h8000000000000000, 16'h0001, 64'h8000000000000000);
    send(16'h0000, 64'h8000000000000000, 16'h0000, 64'h0);
    send(16'h0001, 64'h8000000000000000, 16'h0000, 64'h0);
    send(16'h0000, 64'h1, 16'h0000, 64'h0);
    send(16'h7ffe, 64'hffffffffffffffff, 16'h7fff, 64'h8000000000000000);
    send(16'hfffe, 64'hffffffffffffffff, 16'hffff, 64'h8000000000000000);
    send(16'h7fff, 64'h8000000000000000, 16'h0000, 64'h0);
    send(16'h7fff, 64'h8000000000000001, 16'h0000, 64'h0);
    send(16'h0000, 64'h0, 16'hffff, 64'hc000000000000000);
    send(16'h7fff, 64'h8000000000000005, 16'hffff, 64'h8000000000000009);
    send(16'hffff, 64'h8000000000000009, 16'h7fff, 64'h8000000000000009);
    send(16'h3fff, 64'h4000000000000000, 16'h0000, 64'h0);
    send(16'h0000, 64'h0, 16'h7fff, 64'h0);
    send(16'h7fff, 64'h4000000000000000, 16'h0000, 64'h0);
    send(16'h0000, 64'h7fffffffffffffff, 16'h0000, 64'h8000000000000000);
    send(16'h4000, 64'hffffffffffffffff, 16'h0000, 64'h0);
    send(16'h4000, 64'hffffffffffffffff, 16'h7fff, 64'h8000000000000000);
    drain();
    random_items(140);
    send_idle = 48;
    random_items(140);
    drain();
    send_idle = 0;
    recv_stall = 48;
    random_items(140);
    send_idle = 31;
    recv_stall = 31;
    random_items(140);
    drain();
    recv_stall = 0;
    repeat (10) @(posedge clk);
    $display("Covered %0d transfers in, %0d results out, directed and random,", n_in, n_out);
    $display("across idle and stall phases of sender and receiver.");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== next_representable_ext80.f =====
+incdir+src
src/nrx_pkg.sv
src/next_representable_ext80.sv
tb/next_representable_ext80_tb.sv
